>>> design/qpe_pkg.sv
package qpe_pkg;

  localparam int MaxChars = 5;

  localparam logic [1:0] CLS_OTHER   = 2'd0;
  localparam logic [1:0] CLS_NEWLINE = 2'd1;
  localparam logic [1:0] CLS_BLANK   = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [0:0] REG_BREAK_LINES    = 1'd0;
  localparam logic [0:0] REG_WRAP_THRESHOLD = 1'd1;

  typedef struct packed {
    logic [6:0] line_count;
    logic [1:0] prev_class;
  } qpe_state_t;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [2:0]               count;
    logic                     last;
  } qpe_group_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end else begin
      return 8'h37 + {4'h0, nib};
    end
  endfunction

endpackage

>>> design/qpe_encode.sv
module qpe_encode (
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  qpe_pkg::qpe_state_t state,
  input  logic                break_lines,
  input  logic [6:0]          wrap_threshold,
  output qpe_pkg::qpe_group_t group,
  output qpe_pkg::qpe_state_t state_next
);
  import qpe_pkg::*;

  logic                     esc;
  logic [7:0]               cnt;
  logic [7:0]               cnt_wrap;
  logic [1:0]               cls;
  logic [1:0]               cls_wrap;
  logic                     wrap;
  logic                     soft_brk;
  logic [2:0]               n;
  logic [MaxChars-1:0][7:0] ch;

  always_comb begin
    esc = (data_byte < CH_SPACE && data_byte != CH_LF && data_byte != CH_TAB) ||
          (data_byte == CH_EQ) || (data_byte >= CH_DEL) ||
          (state.line_count == 7'd0 && data_byte == CH_DOT) ||
          (state.prev_class == CLS_NEWLINE && data_byte == CH_F);

    ch = '0;
    if (esc) begin
      ch[0] = CH_EQ;
      ch[1] = hex_digit(data_byte[7:4]);
      ch[2] = hex_digit(data_byte[3:0]);
      n     = 3'd3;
      cnt   = {1'b0, state.line_count} + 8'd3;
      cls   = CLS_OTHER;
    end else if (data_byte == CH_LF) begin
      if (state.prev_class == CLS_BLANK) begin
        ch[0] = CH_EQ;
        ch[1] = CH_LF;
        ch[2] = CH_LF;
        n     = 3'd3;
      end else begin
        ch[0] = CH_LF;
        n     = 3'd1;
      end
      cnt = 8'd0;
      cls = CLS_NEWLINE;
    end else begin
      ch[0] = data_byte;
      n     = 3'd1;
      cnt   = {1'b0, state.line_count} + 8'd1;
      cls   = (data_byte == CH_SPACE || data_byte == CH_TAB) ? CLS_BLANK : CLS_OTHER;
    end

    wrap     = cnt > {1'b0, wrap_threshold};
    cnt_wrap = wrap ? 8'd0 : cnt;
    cls_wrap = (wrap && break_lines) ? CLS_NEWLINE : cls;
    soft_brk = break_lines && (wrap || (last_byte && cnt_wrap != 8'd0));

    // append soft break after the body
    if (soft_brk) begin
      for (int i = 0; i < MaxChars; i++) begin
        if (3'(i) == n) begin
          ch[i] = CH_EQ;
        end
        if (3'(i) == n + 3'd1) begin
          ch[i] = CH_LF;
        end
      end
    end

    group.chars = ch;
    group.count = soft_brk ? n + 3'd2 : n;
    group.last  = last_byte;

    if (last_byte) begin
      state_next.line_count = 7'd0;
      state_next.prev_class = CLS_OTHER;
    end else begin
      state_next.line_count = cnt_wrap[6:0];
      state_next.prev_class = cls_wrap;
    end
  end

endmodule

>>> design/qpe_serial.sv
module qpe_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  qpe_pkg::qpe_group_t group,
  output logic                free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,  // out_char
  output logic                m_tuser,  // out_last
  output logic                m_tlast   // stream_end
);
  import qpe_pkg::*;

  logic [MaxChars-1:0][7:0] chars;
  logic [2:0]               remaining;
  logic                     last;
  logic                     take;
  logic                     final_beat;

  assign take       = m_tvalid && m_tready;
  assign final_beat = remaining == 3'd1;
  assign free       = !m_tvalid || (take && final_beat);

  assign m_tvalid = remaining != 3'd0;
  assign m_tdata  = chars[0];
  assign m_tuser  = final_beat;
  assign m_tlast  = final_beat && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 3'd0;
    end else if (load) begin
      remaining <= group.count;
    end else if (take) begin
      remaining <= remaining - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= group.chars;
      last  <= group.last;
    end else if (take) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        chars[i] <= chars[i+1];
      end
      chars[MaxChars-1] <= '0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    remaining <= 3'(MaxChars))
    else $error("char count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!m_tvalid || (take && final_beat)))
    else $error("group loaded over pending chars");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && final_beat && !load) |=> !m_tvalid)
    else $error("valid after final beat");

  a_end_marks_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("stream end not on group end");

endmodule

>>> design/quoted_printable_encoder.sv
// Quoted-printable encoder. Each input beat is one raw byte (tlast marks the
// final byte of a stream) and yields one to five ASCII characters, sent one
// per output beat; tuser marks the last character of each input byte, tlast
// the last character of the stream. Escapes, hard and soft line breaks and
// the line count are worked out combinationally when a byte is accepted, and
// the characters then drain from a five-entry shift register, so an input byte
// occupies the block until its last character has been taken. A new byte is
// taken in the same cycle as the final character of the previous one.
// Registers: index 0 break_lines (reset 1), index 1 wrap_threshold (reset 72);
// write them only while the block is idle.
module quoted_printable_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char
  output logic       m_tuser,   // out_last
  output logic       m_tlast    // stream_end
);
  import qpe_pkg::*;

  logic       break_lines;
  logic [6:0] wrap_threshold;
  qpe_state_t state;
  qpe_state_t state_next;
  qpe_group_t group;
  logic       load;
  logic       free;

  assign s_tready = free;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      break_lines    <= 1'b1;
      wrap_threshold <= 7'd72;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BREAK_LINES:    break_lines    <= cfg_data[0];
        REG_WRAP_THRESHOLD: wrap_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.line_count <= 7'd0;
      state.prev_class <= CLS_OTHER;
    end else if (load) begin
      state <= state_next;
    end
  end

  qpe_encode u_encode (
    .data_byte      (s_tdata),
    .last_byte      (s_tlast),
    .state          (state),
    .break_lines    (break_lines),
    .wrap_threshold (wrap_threshold),
    .group          (group),
    .state_next     (state_next)
  );

  qpe_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .group    (group),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sv/tb_quoted_printable_encoder.sv
`timescale 1ns / 100ps

module tb_quoted_printable_encoder;
  import qpe_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;
  localparam int MaxReports = 10;
  localparam logic [6:0] DefaultWrap = 7'd72;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_byte;
    logic       end_of_stream;
  } qp_char_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [6:0] cfg_data;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  quoted_printable_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  qp_char_t   pending_chars[$];
  logic [7:0] step_chars[$];
  string      hex_chars = "0123456789ABCDEF";

  logic       brk_en;
  logic [6:0] wrap_at;
  int         col_count;
  logic [1:0] prev_kind;

  int fail_count;
  int bytes_in;
  int chars_out;
  int streams_in;
  int cycle_count;

  bit   jitter;
  int   hold_reqs;
  int   holds_done;
  int   hold_left;
  int   rx_wait;
  logic rx_ready;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_text_byte(input bit allow_lf);
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 50) b = 8'($urandom_range(33, 126));
    else if (r < 64) b = CH_SPACE;
    else if (r < 69) b = CH_TAB;
    else if (r < 77) b = allow_lf ? CH_LF : CH_SPACE;
    else if (r < 82) b = CH_DOT;
    else if (r < 87) b = CH_F;
    else if (r < 90) b = CH_EQ;
    else if (r < 96) b = 8'($urandom_range(0, 255));
    else b = 8'($urandom_range(0, 31));
    return b;
  endfunction

  // expected characters for one raw byte, appended to pending_chars
  function automatic void encode_byte(input logic [7:0] c, input logic lst);
    int cnt;
    logic [1:0] cls;
    qp_char_t item;
    cnt = col_count;
    cls = prev_kind;
    step_chars.delete();
    if ((c < CH_SPACE && c != CH_LF && c != CH_TAB) || c == CH_EQ || c >= CH_DEL ||
        (cnt == 0 && c == CH_DOT) || (cls == CLS_NEWLINE && c == CH_F)) begin
      step_chars.push_back(CH_EQ);
      step_chars.push_back(hex_chars[c[7:4]]);
      step_chars.push_back(hex_chars[c[3:0]]);
      cnt += 3;
      cls = CLS_OTHER;
    end else if (c == CH_LF) begin
      if (cls == CLS_BLANK) begin
        step_chars.push_back(CH_EQ);
        step_chars.push_back(CH_LF);
      end
      step_chars.push_back(CH_LF);
      cnt = 0;
      cls = CLS_NEWLINE;
    end else begin
      step_chars.push_back(c);
      cnt += 1;
      cls = (c == CH_SPACE || c == CH_TAB) ? CLS_BLANK : CLS_OTHER;
    end
    if (cnt > wrap_at) begin
      if (brk_en) begin
        step_chars.push_back(CH_EQ);
        step_chars.push_back(CH_LF);
        cls = CLS_NEWLINE;
      end
      cnt = 0;
    end
    if (lst) begin
      if (cnt > 0 && brk_en) begin
        step_chars.push_back(CH_EQ);
        step_chars.push_back(CH_LF);
      end
      cnt = 0;
      cls = CLS_OTHER;
    end
    foreach (step_chars[i]) begin
      item.ch = step_chars[i];
      item.end_of_byte = (i == step_chars.size() - 1);
      item.end_of_stream = lst && item.end_of_byte;
      pending_chars.push_back(item);
    end
    col_count = cnt;
    prev_kind = cls;
  endfunction

  // register writes, accepted bytes and output beats, in that order
  always @(posedge clk) begin
    qp_char_t want;
    if (rst) begin
      brk_en = 1'b1;
      wrap_at = DefaultWrap;
      col_count = 0;
      prev_kind = CLS_OTHER;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BREAK_LINES: brk_en = cfg_data[0];
          REG_WRAP_THRESHOLD: wrap_at = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
        bytes_in++;
        if (s_tlast) streams_in++;
      end
      if (m_tvalid && m_tready) begin
        chars_out++;
        if (pending_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected beat: got %h user %b last %b", m_tdata, m_tuser, m_tlast);
        end else begin
          want = pending_chars.pop_front();
          if (m_tdata !== want.ch || m_tuser !== want.end_of_byte ||
              m_tlast !== want.end_of_stream) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("char mismatch: want %h/%b/%b got %h/%b/%b", want.ch,
                       want.end_of_byte, want.end_of_stream, m_tdata, m_tuser, m_tlast);
          end
        end
      end
    end
  end

  // receiver: long hold on request, random stalls while jitter is on
  always @(posedge clk) begin
    if (hold_reqs != holds_done) begin
      holds_done = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      rx_ready = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      rx_ready = 1'b0;
    end else begin
      rx_ready = 1'b1;
      if (jitter) rx_wait = pick_gap();
    end
    m_tready <= rx_ready;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d chars outstanding", cycle_count,
               pending_chars.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = jitter ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_stream(input int len, input bit allow_lf);
    for (int i = 0; i < len; i++) send_byte(pick_text_byte(allow_lf), i == len - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(input bit brk, input logic [6:0] thr);
    wait_drained();
    write_reg(REG_BREAK_LINES, {6'd0, brk});
    write_reg(REG_WRAP_THRESHOLD, thr);
  endtask

  task automatic test_plain_chars();
    logic [7:0] text[$];
    text = '{8'h41, 8'h7A, 8'h7E, 8'h21, CH_SPACE, CH_TAB, 8'h78, CH_LF,
             CH_DOT, CH_DOT, CH_LF, CH_F, CH_F};
    foreach (text[i]) send_byte(text[i], 1'b0);
  endtask

  task automatic test_escapes();
    logic [7:0] text[$];
    text = '{8'h00, 8'h1F, CH_EQ, CH_DEL, 8'h80, 8'hFF, CH_SPACE, CH_LF,
             CH_TAB, CH_LF};
    foreach (text[i]) send_byte(text[i], 1'b0);
    send_byte(8'h71, 1'b1);
    send_byte(CH_LF, 1'b1);
    send_byte(CH_EQ, 1'b1);
  endtask

  task automatic test_wrap_settings();
    bit brks[6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    int thrs[6] = '{0, 0, 8, 8, 127, 72};
    for (int i = 0; i < 6; i++) begin
      set_mode(brks[i], 7'(thrs[i]));
      send_stream((thrs[i] > 8) ? 4 : thrs[i] + 4, 1'b1);
    end
  endtask

  task automatic test_backpressure();
    set_mode(1'b1, 7'd8);
    jitter = 1'b0;
    hold_reqs++;
    send_stream(16, 1'b1);
    wait_drained();
    jitter = 1'b1;
  endtask

  task automatic test_random_streams();
    int sent;
    int len;
    int r;
    logic [6:0] thr;
    sent = 0;
    while (sent < 25) begin
      len = $urandom_range(1, 10);
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        if (r < 7) thr = 7'($urandom_range(0, 20));
        else if (r < 9) thr = 7'($urandom_range(0, 127));
        else thr = 7'd127;
        set_mode(1'($urandom_range(0, 1)), thr);
      end
      jitter = ($urandom_range(0, 3) != 0);
      send_stream(len, 1'b1);
      sent += len;
    end
    jitter = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_BREAK_LINES;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    m_tready <= 1'b0;
    jitter = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_plain_chars();
    test_escapes();
    test_wrap_settings();
    test_backpressure();
    test_random_streams();
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_chars.size() != 0) begin
      fail_count += pending_chars.size();
      $display("%0d expected chars never arrived", pending_chars.size());
    end
    $display("covered %0d input bytes in %0d streams, %0d output chars checked",
             bytes_in, streams_in, chars_out);
    $display("breaks on and off, wrap thresholds 0 to 127, long receiver hold, random gaps");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/qpe_pkg.sv
design/qpe_encode.sv
design/qpe_serial.sv
design/quoted_printable_encoder.sv
tb/sv/tb_quoted_printable_encoder.sv
